// ----- src/mp2a_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2a_pkg: shared definitions for the 2-D max pooling block
// Sizes, field widths, register indexes, and the clamping helpers that turn
// raw register writes into usable window and plane dimensions.
// ----------------------------------------------------------------------------
package mp2a_pkg;

   localparam int MAX_KERNEL = 4;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Field widths.
   localparam int SAMPLE_W   = 16;
   localparam int KS_W       = 3;
   localparam int ST_W       = 3;
   localparam int DIM_W      = 11;
   localparam int INDEX_W    = 20;
   localparam int OUT_ROW_W  = 10;
   localparam int OUT_COL_W  = 10;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;

   // Derived sizes.
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int CMP_W      = DIM_W + 2;
   localparam int AGE_W      = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int HIST_N     = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int LINE_W     = MAX_KERNEL * SAMPLE_W;
   localparam int LEAF_N     = MAX_KERNEL * MAX_KERNEL;
   localparam int TREE_LVLS  = $clog2(LEAF_N);
   localparam int TREE_LEAVES = 1 << TREE_LVLS;
   localparam int CAND_N     = 1 << (TREE_LVLS / 2);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // One column of the window, newest row in element 0.
   typedef logic [MAX_KERNEL-1:0][SAMPLE_W-1:0] column_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KERNEL_SIZE  = 2'd0,
      CSR_STRIDE       = 2'd1,
      CSR_PLANE_HEIGHT = 2'd2,
      CSR_PLANE_WIDTH  = 2'd3
   } csr_index_type;

   // A contender in the argmax tree; ages count back from the newest sample.
   typedef struct packed {
      logic                    valid;
      logic signed [SAMPLE_W-1:0] value;
      logic [AGE_W-1:0]        row_age;
      logic [AGE_W-1:0]        col_age;
   } cand_type;

   function automatic logic [KS_W-1:0] eff_kernel(input logic [KS_W-1:0] v);
      if (v == '0) begin
         return KS_W'(1);
      end
      if (int'(v) > MAX_KERNEL) begin
         return KS_W'(MAX_KERNEL);
      end
      return v;
   endfunction

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (int'(v) > maxv) begin
         return DIM_W'(maxv);
      end
      return v;
   endfunction

endpackage

// ----- src/mp2a_if.sv -----
// ----------------------------------------------------------------------------
// mp2a_if: channel interfaces of the 2-D max pooling block
// Sample input, pooled result output and register write channels, each with
// valid/ready flow control and a source and a sink modport.
// ----------------------------------------------------------------------------
interface mp2a_req_if;
   import mp2a_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface mp2a_rsp_if;
   import mp2a_pkg::*;

   logic                 valid;
   logic                 ready;
   sample_type           pooled_value;
   logic [INDEX_W-1:0]   argmax_index;
   logic [OUT_ROW_W-1:0] out_row;
   logic [OUT_COL_W-1:0] out_col;
   logic                 plane_done;

   modport source (output valid, output pooled_value, output argmax_index,
                   output out_row, output out_col, output plane_done, input ready);
   modport sink (input valid, input pooled_value, input argmax_index,
                 input out_row, input out_col, input plane_done, output ready);
endinterface

interface mp2a_csr_if;
   import mp2a_pkg::*;

   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/max_pool_2d_argmax.sv -----
// Path: the sample that completes a window passes the input, candidate, best
//   and output registers in turn; each can hold under back-pressure.
// Throughput: one sample per cycle unless stalled; the line store does one read
//   and one write per cycle, bypassed when consecutive samples hit one column.
// Reset: synchronous; registers return to kernel 2, stride 2, 1024 x 1024,
//   position counters clear, the line store is not cleared.
// ----------------------------------------------------------------------------
// max_pool_2d_argmax: streaming 2-D max pooling with argmax
// Samples arrive in raster order. Each line store word holds one column of
// the last rows; a shift register of columns forms the window, and a
// two-stage comparison tree picks the first maximum in scan order.
// ----------------------------------------------------------------------------
module max_pool_2d_argmax (
   input logic        clock,
   input logic        reset,
   mp2a_req_if.sink   req_chan,
   mp2a_rsp_if.source rsp_chan,
   mp2a_csr_if.sink   csr_chan
);
   import mp2a_pkg::*;

   function automatic cand_type pick(input cand_type early, input cand_type late);
      if (late.valid && (!early.valid || ($signed(late.value) > $signed(early.value)))) begin
         return late;
      end
      return early;
   endfunction

   // Configuration.
   logic [KS_W-1:0]  kernel_ff, kernel_in;
   logic [ST_W-1:0]  stride_ff, stride_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [ST_W-1:0]  step;
   logic             csr_write;

   // Position tracking.
   logic [ROW_W-1:0]   row_cnt_ff, row_cnt_in;
   logic [COL_W-1:0]   col_cnt_ff, col_cnt_in;
   logic [ST_W-1:0]    row_ph_ff, row_ph_in;
   logic [ST_W-1:0]    col_ph_ff, col_ph_in;
   logic [ROW_W-1:0]   orow_ff, orow_in;
   logic [COL_W-1:0]   ocol_ff, ocol_in;
   logic [INDEX_W-1:0] flat_ff, flat_in;
   logic               row_act, col_act, row_last, col_last;
   logic               win_hit, win_done;

   // Flow control.
   logic out_free, s3_free, s2_free, s1_free;
   logic s1_adv, accept, s2_load, s3_load, out_load;

   // Input stage.
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_hit_ff;
   logic               s1_done_ff;
   sample_type         s1_sample_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_orow_ff;
   logic [COL_W-1:0]   s1_ocol_ff;
   logic [INDEX_W-1:0] s1_flat_ff;
   logic               fwd_ff;
   column_type         fwd_col_ff;
   column_type         ram_col;
   column_type         prev_col;
   column_type         cur_col;
   column_type         hist_ff [HIST_N];
   column_type         win [MAX_KERNEL];
   cand_type           s1_node [2*TREE_LEAVES];

   // Candidate stage.
   logic               s2_valid_ff, s2_valid_in;
   cand_type           s2_cand_ff [CAND_N];
   logic               s2_done_ff;
   logic [ROW_W-1:0]   s2_orow_ff;
   logic [COL_W-1:0]   s2_ocol_ff;
   logic [INDEX_W-1:0] s2_flat_ff;
   cand_type           s2_node [2*CAND_N];

   // Best stage.
   logic               s3_valid_ff, s3_valid_in;
   sample_type         s3_value_ff;
   logic [AGE_W-1:0]   s3_ra_ff;
   logic [AGE_W-1:0]   s3_ca_ff;
   logic               s3_done_ff;
   logic [ROW_W-1:0]   s3_orow_ff;
   logic [COL_W-1:0]   s3_ocol_ff;
   logic [INDEX_W-1:0] s3_flat_ff;
   logic [DIM_W+AGE_W-1:0] row_off;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   sample_type           rsp_value_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic [OUT_ROW_W-1:0] rsp_row_ff;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic                 rsp_done_ff;

   // ---------------------------------------------------------------- config
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   // A stride of zero means windows that touch without overlap.
   assign step = (stride_ff == '0) ? ST_W'(kernel_ff) : stride_ff;

   always_comb begin
      kernel_in = kernel_ff;
      stride_in = stride_ff;
      height_in = height_ff;
      width_in  = width_ff;
      if (csr_write) begin
         unique case (csr_chan.index)
            CSR_KERNEL_SIZE:  kernel_in = eff_kernel(KS_W'(csr_chan.data));
            CSR_STRIDE:       stride_in = ST_W'(csr_chan.data);
            CSR_PLANE_HEIGHT: height_in = eff_dim(DIM_W'(csr_chan.data), MAX_HEIGHT);
            CSR_PLANE_WIDTH:  width_in  = eff_dim(DIM_W'(csr_chan.data), MAX_WIDTH);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= KS_W'(2);
         stride_ff <= ST_W'(2);
         height_ff <= DIM_W'(MAX_HEIGHT);
         width_ff  <= DIM_W'(MAX_WIDTH);
      end else begin
         kernel_ff <= kernel_in;
         stride_ff <= stride_in;
         height_ff <= height_in;
         width_ff  <= width_in;
      end
   end

   // ------------------------------------------------------------ flow control
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_chan.ready;
      s3_free   = !s3_valid_ff || out_free;
      s2_free   = !s2_valid_ff || s3_free;
      // Samples that complete no window leave the input stage unconditionally.
      s1_adv    = s1_valid_ff && (!s1_hit_ff || s2_free);
      s1_free   = !s1_valid_ff || s1_adv;
      accept    = req_chan.valid && s1_free;
      s2_load   = s1_adv && s1_hit_ff;
      s3_load   = s2_valid_ff && s3_free;
      out_load  = s3_valid_ff && out_free;

      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s2_load ? 1'b1 : (s3_free ? 1'b0 : s2_valid_ff);
      s3_valid_in  = s3_load ? 1'b1 : (out_free ? 1'b0 : s3_valid_ff);
      rsp_valid_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   assign req_chan.ready = s1_free;

   // -------------------------------------------------------- position tracking
   always_comb begin
      row_act  = (CMP_W'(row_cnt_ff) + CMP_W'(1)) >= CMP_W'(kernel_ff);
      col_act  = (CMP_W'(col_cnt_ff) + CMP_W'(1)) >= CMP_W'(kernel_ff);
      row_last = (CMP_W'(row_cnt_ff) + CMP_W'(1)) >= CMP_W'(height_ff);
      col_last = (CMP_W'(col_cnt_ff) + CMP_W'(1)) >= CMP_W'(width_ff);
      win_hit  = row_act && col_act && (row_ph_ff == '0) && (col_ph_ff == '0);
      // The last window of a plane is the one after which no origin fits.
      win_done = win_hit
               && ((CMP_W'(row_cnt_ff) + CMP_W'(step)) >= CMP_W'(height_ff))
               && ((CMP_W'(col_cnt_ff) + CMP_W'(step)) >= CMP_W'(width_ff));
   end

   always_comb begin
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      row_ph_in  = row_ph_ff;
      col_ph_in  = col_ph_ff;
      orow_in    = orow_ff;
      ocol_in    = ocol_ff;
      flat_in    = flat_ff;
      if (csr_write) begin
         row_cnt_in = '0;
         col_cnt_in = '0;
         row_ph_in  = '0;
         col_ph_in  = '0;
         orow_in    = '0;
         ocol_in    = '0;
         flat_in    = '0;
      end else if (accept) begin
         flat_in = (row_last && col_last) ? '0 : flat_ff + 1'b1;
         if (col_last) begin
            col_cnt_in = '0;
            col_ph_in  = '0;
            ocol_in    = '0;
            if (row_last) begin
               row_cnt_in = '0;
               row_ph_in  = '0;
               orow_in    = '0;
            end else begin
               row_cnt_in = row_cnt_ff + 1'b1;
               // Phases stay at zero until the first row that can close a window.
               if (row_act) begin
                  if (row_ph_ff + 1'b1 == step) begin
                     row_ph_in = '0;
                     orow_in   = orow_ff + 1'b1;
                  end else begin
                     row_ph_in = row_ph_ff + 1'b1;
                  end
               end
            end
         end else begin
            col_cnt_in = col_cnt_ff + 1'b1;
            if (col_act) begin
               if (col_ph_ff + 1'b1 == step) begin
                  col_ph_in = '0;
                  ocol_in   = ocol_ff + 1'b1;
               end else begin
                  col_ph_in = col_ph_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
         col_cnt_ff <= '0;
         row_ph_ff  <= '0;
         col_ph_ff  <= '0;
         orow_ff    <= '0;
         ocol_ff    <= '0;
         flat_ff    <= '0;
      end else begin
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
         row_ph_ff  <= row_ph_in;
         col_ph_ff  <= col_ph_in;
         orow_ff    <= orow_in;
         ocol_ff    <= ocol_in;
         flat_ff    <= flat_in;
      end
   end

   // ------------------------------------------------------------- input stage
   mp2a_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) line_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (cur_col),
      .rd_en   (accept),
      .rd_addr (col_cnt_ff),
      .rd_data (ram_col)
   );

   always_comb begin
      // With a one-column plane the column just written is read again at once.
      prev_col   = fwd_ff ? fwd_col_ff : ram_col;
      cur_col[0] = s1_sample_ff;
      for (int i = 1; i < MAX_KERNEL; i++) begin
         cur_col[i] = prev_col[i-1];
      end
      win[0] = cur_col;
      for (int c = 1; c < MAX_KERNEL; c++) begin
         win[c] = hist_ff[c-1];
      end
   end

   // Leaves are ordered oldest row first, then oldest column first, which is
   // the scan order inside the window; the earlier contender wins a tie.
   always_comb begin
      int ra;
      int ca;
      for (int n = 0; n < 2*TREE_LEAVES; n++) begin
         s1_node[n] = '0;
      end
      for (int e = 0; e < LEAF_N; e++) begin
         ra = MAX_KERNEL - 1 - e / MAX_KERNEL;
         ca = MAX_KERNEL - 1 - e % MAX_KERNEL;
         s1_node[TREE_LEAVES + e].valid   = (ra < int'(kernel_ff)) && (ca < int'(kernel_ff));
         s1_node[TREE_LEAVES + e].value   = win[ca][ra];
         s1_node[TREE_LEAVES + e].row_age = AGE_W'(ra);
         s1_node[TREE_LEAVES + e].col_age = AGE_W'(ca);
      end
      for (int n = TREE_LEAVES - 1; n >= CAND_N; n--) begin
         s1_node[n] = pick(s1_node[2*n], s1_node[2*n+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hit_ff    <= win_hit;
         s1_done_ff   <= win_done;
         s1_sample_ff <= req_chan.sample;
         s1_col_ff    <= col_cnt_ff;
         s1_orow_ff   <= orow_ff;
         s1_ocol_ff   <= ocol_ff;
         s1_flat_ff   <= flat_ff;
         fwd_ff       <= s1_adv && (s1_col_ff == col_cnt_ff);
         fwd_col_ff   <= cur_col;
      end
      if (s1_adv) begin
         hist_ff[0] <= cur_col;
         for (int i = 1; i < HIST_N; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   // --------------------------------------------------------- candidate stage
   always_comb begin
      for (int n = 0; n < 2*CAND_N; n++) begin
         s2_node[n] = '0;
      end
      for (int i = 0; i < CAND_N; i++) begin
         s2_node[CAND_N + i] = s2_cand_ff[i];
      end
      for (int n = CAND_N - 1; n >= 1; n--) begin
         s2_node[n] = pick(s2_node[2*n], s2_node[2*n+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         for (int i = 0; i < CAND_N; i++) begin
            s2_cand_ff[i] <= s1_node[CAND_N + i];
         end
         s2_done_ff <= s1_done_ff;
         s2_orow_ff <= s1_orow_ff;
         s2_ocol_ff <= s1_ocol_ff;
         s2_flat_ff <= s1_flat_ff;
      end
      if (s3_load) begin
         s3_value_ff <= s2_node[1].value;
         s3_ra_ff    <= s2_node[1].row_age;
         s3_ca_ff    <= s2_node[1].col_age;
         s3_done_ff  <= s2_done_ff;
         s3_orow_ff  <= s2_orow_ff;
         s3_ocol_ff  <= s2_ocol_ff;
         s3_flat_ff  <= s2_flat_ff;
      end
   end

   // ---------------------------------------------------------- output register
   // The flat index of the closing sample minus the winner's offset back.
   assign row_off = (DIM_W+AGE_W)'(s3_ra_ff) * (DIM_W+AGE_W)'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff <= s3_value_ff;
         rsp_index_ff <= s3_flat_ff - INDEX_W'(row_off) - INDEX_W'(s3_ca_ff);
         rsp_row_ff   <= OUT_ROW_W'(s3_orow_ff);
         rsp_col_ff   <= OUT_COL_W'(s3_ocol_ff);
         rsp_done_ff  <= s3_done_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pooled_value = rsp_value_ff;
   assign rsp_chan.argmax_index = rsp_index_ff;
   assign rsp_chan.out_row      = rsp_row_ff;
   assign rsp_chan.out_col      = rsp_col_ff;
   assign rsp_chan.plane_done   = rsp_done_ff;

   // -------------------------------------------------------------- assertions
   col_in_plane: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(col_cnt_ff) < CMP_W'(width_ff) && CMP_W'(row_cnt_ff) < CMP_W'(height_ff))
      else $error("position counter outside the plane");

   hit_reaches_tree: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_hit_ff && s1_adv |=> s2_valid_ff)
      else $error("completed window lost between input and candidate stages");

   newest_always_contends: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_cand_ff[CAND_N-1].valid)
      else $error("candidate holding the newest sample is not valid");

   winner_inside_window: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (KS_W'(s3_ra_ff) < kernel_ff) && (KS_W'(s3_ca_ff) < kernel_ff))
      else $error("argmax winner lies outside the window");

endmodule

// ----- src/mp2a_ram.sv -----
// ----------------------------------------------------------------------------
// mp2a_ram: simple dual-port RAM
// One write port and one read port; read data is registered and a read of
// the address being written returns the old contents.
// ----------------------------------------------------------------------------
module mp2a_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/pool_checker.sv -----
// ----------------------------------------------------------------------------
// pool_checker: result predictor and scoreboard for max_pool_2d_argmax
// Watches the register, sample and result channels. It keeps its own line
// store, position counters and settings, and predicts every pooled value with
// its argmax. It then compares each result transfer field by field with the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module pool_checker (
   input  logic clock,
   input  logic reset,
   mp2a_req_if  req_mon,
   mp2a_rsp_if  rsp_mon,
   mp2a_csr_if  csr_mon,
   output int   fail_count,
   output int   pending
);
   import mp2a_pkg::*;

   typedef struct {
      sample_type           value;
      logic [INDEX_W-1:0]   index;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 done;
   } pool_result_type;

   pool_result_type pooled_q[$];
   pool_result_type want;
   sample_type      rows_seen [MAX_KERNEL][MAX_WIDTH];
   logic [KS_W-1:0]  kernel_reg;
   logic [ST_W-1:0]  stride_reg;
   logic [DIM_W-1:0] height_reg;
   logic [DIM_W-1:0] width_reg;
   int row_pos;
   int col_pos;

   function automatic int clamp_dim(input int v, input int top);
      if (v == 0) begin
         return 1;
      end
      return (v > top) ? top : v;
   endfunction

   // Stores the sample and, when it closes a window on the stride grid,
   // queues the window maximum with the position of its earliest occurrence.
   task automatic pool_sample(input sample_type smp);
      int k, s, h, w, r0, c0, best_r, best_c, hout, wout, i, j;
      sample_type best, v;
      pool_result_type res;
      if (kernel_reg == '0) begin
         k = 1;
      end else begin
         k = (int'(kernel_reg) > MAX_KERNEL) ? MAX_KERNEL : int'(kernel_reg);
      end
      s = (stride_reg == '0) ? k : int'(stride_reg);
      h = clamp_dim(int'(height_reg), MAX_HEIGHT);
      w = clamp_dim(int'(width_reg), MAX_WIDTH);
      rows_seen[row_pos % MAX_KERNEL][col_pos] = smp;
      if (row_pos + 1 >= k && col_pos + 1 >= k &&
          (row_pos + 1 - k) % s == 0 && (col_pos + 1 - k) % s == 0) begin
         r0 = row_pos + 1 - k;
         c0 = col_pos + 1 - k;
         best = rows_seen[r0 % MAX_KERNEL][c0];
         best_r = r0;
         best_c = c0;
         for (i = 0; i < k; i++) begin
            for (j = 0; j < k; j++) begin
               v = rows_seen[(r0 + i) % MAX_KERNEL][c0 + j];
               // Only a strictly larger value moves the argmax.
               if (v > best) begin
                  best = v;
                  best_r = r0 + i;
                  best_c = c0 + j;
               end
            end
         end
         hout = (h >= k) ? (h - k) / s + 1 : 0;
         wout = (w >= k) ? (w - k) / s + 1 : 0;
         res.value = best;
         res.index = INDEX_W'(best_r * w + best_c);
         res.row = OUT_ROW_W'(r0 / s);
         res.col = OUT_COL_W'(c0 / s);
         res.done = (hout > 0 && wout > 0 && r0 / s + 1 == hout && c0 / s + 1 == wout);
         pooled_q.push_back(res);
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   task automatic compare_field(input string name, input logic signed [31:0] exp_val,
                                input logic signed [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pooled_q.delete();
         kernel_reg = KS_W'(2);
         stride_reg = ST_W'(2);
         height_reg = DIM_W'(1024);
         width_reg = DIM_W'(1024);
         row_pos = 0;
         col_pos = 0;
         fail_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_KERNEL_SIZE:  kernel_reg = csr_mon.data[KS_W-1:0];
               CSR_STRIDE:       stride_reg = csr_mon.data[ST_W-1:0];
               CSR_PLANE_HEIGHT: height_reg = csr_mon.data;
               CSR_PLANE_WIDTH:  width_reg = csr_mon.data;
               default: ;
            endcase
            // Any register write starts a new plane.
            row_pos = 0;
            col_pos = 0;
         end
         if (req_mon.valid && req_mon.ready) begin
            pool_sample(req_mon.sample);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pooled_q.size() == 0) begin
               $error("result transfer with no pooled value pending");
               fail_count++;
            end else begin
               want = pooled_q.pop_front();
               compare_field("pooled_value", want.value, rsp_mon.pooled_value);
               compare_field("argmax_index", want.index, rsp_mon.argmax_index);
               compare_field("out_row", want.row, rsp_mon.out_row);
               compare_field("out_col", want.col, rsp_mon.out_col);
               compare_field("plane_done", want.done, rsp_mon.plane_done);
            end
         end
      end
      pending = pooled_q.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for max_pool_2d_argmax
// Streams directed and random feature planes under many pooling settings,
// with random gaps on the sample side and random stalls on the result side.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
   import mp2a_pkg::*;

   localparam int RAND_ITEMS  = 740;
   localparam int WIDE_ITEMS  = 48;
   localparam int CYCLE_LIMIT = 400000;
   localparam sample_type LOWEST  = 16'sh8000;
   localparam sample_type HIGHEST = 16'sh7FFF;

   logic clock;
   logic reset;
   int fail_count;
   int pending;
   int cycle_count;
   int sent;
   int rsp_count;
   int setting_count;
   bit req_quiet;
   bit rsp_quiet;
   sample_type script[$];

   mp2a_req_if req_bus();
   mp2a_rsp_if rsp_bus();
   mp2a_csr_if csr_bus();

   max_pool_2d_argmax u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   pool_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   // Result side: a random stall before each transfer, with quiet stretches.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      rsp_quiet = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            rsp_quiet = !rsp_quiet;
         end
         stall = rsp_quiet ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         rsp_count++;
         @(negedge clock);
      end
   end

   function automatic sample_type next_sample(input int mode);
      case (mode)
         // Narrow range, so windows are full of ties.
         1: return sample_type'(int'($urandom_range(0, 4)) - 2);
         2: begin
            case ($urandom_range(0, 4))
               0: return LOWEST;
               1: return HIGHEST;
               2: return sample_type'(-1);
               3: return sample_type'(0);
               default: return sample_type'($urandom);
            endcase
         end
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 19))
         0: return 0;
         1: return $urandom_range(MAX_WIDTH + 1, (1 << DIM_W) - 1);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   task automatic send_sample(input sample_type value);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic play_script();
      foreach (script[i]) begin
         send_sample(script[i]);
      end
   endtask

   // Lets every pending result drain, then waits on for samples still in the
   // pipeline that close no window.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Writes all four registers, starting at a random one.
   task automatic load_pool_config(input int k, input int s, input int h, input int w);
      csr_index_type regs [4];
      logic [CSR_DATA_W-1:0] vals [4];
      int rot, n, gap;
      regs = '{CSR_KERNEL_SIZE, CSR_STRIDE, CSR_PLANE_HEIGHT, CSR_PLANE_WIDTH};
      // Bits above the kernel and stride fields carry noise.
      vals[0] = CSR_DATA_W'($urandom);
      vals[0][KS_W-1:0] = KS_W'(k);
      vals[1] = CSR_DATA_W'($urandom);
      vals[1][ST_W-1:0] = ST_W'(s);
      vals[2] = CSR_DATA_W'(h);
      vals[3] = CSR_DATA_W'(w);
      rot = $urandom_range(0, 3);
      for (n = 0; n < 4; n++) begin
         gap = $urandom_range(0, 2);
         if (gap > 0) begin
            csr_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         csr_bus.valid <= 1'b1;
         csr_bus.index <= regs[(n + rot) % 4];
         csr_bus.data <= vals[(n + rot) % 4];
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
         @(negedge clock);
      end
      csr_bus.valid <= 1'b0;
      setting_count++;
   endtask

   initial begin
      int k, s, h, w, hh, ww, n, mode, i, rand_start;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_KERNEL_SIZE;
      csr_bus.data = '0;
      req_quiet = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Settings after reset: a 1024 wide plane, so a few samples close nothing.
      script = '{HIGHEST, LOWEST, 16'sh0100};
      play_script();
      settle();

      // Extremes, a tie for the maximum and an all-equal window.
      load_pool_config(2, 2, 2, 4);
      script = '{HIGHEST, LOWEST, -1, -1, HIGHEST, 0, -1, -1};
      play_script();
      settle();

      // Zero kernel, zero stride and zero height all act as one.
      load_pool_config(0, 0, 0, 3);
      script = '{LOWEST, HIGHEST, 0};
      play_script();
      settle();

      // Oversized kernel clamps to four, still larger than the plane.
      load_pool_config(7, 5, 2, 2);
      script = '{1, 2, 3, 4};
      play_script();
      settle();

      // Oversized width saturates; the start of one row with the widest stride.
      load_pool_config(1, 7, 1, (1 << DIM_W) - 1);
      for (i = 0; i < WIDE_ITEMS; i++) begin
         send_sample(next_sample(0));
      end
      settle();

      rand_start = sent;
      while (sent - rand_start < RAND_ITEMS) begin
         k = $urandom_range(0, 7);
         s = $urandom_range(0, 7);
         h = pick_dim();
         w = pick_dim();
         hh = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
         ww = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
         n = hh * ww * $urandom_range(1, 3);
         if (n > 200) begin
            n = 200;
         end
         mode = $urandom_range(0, 2);
         req_quiet = ($urandom_range(0, 3) == 0);
         load_pool_config(k, s, h, w);
         for (i = 0; i < n; i++) begin
            send_sample(next_sample(mode));
         end
         settle();
      end

      $display("Streamed %0d samples under %0d register settings.", sent, setting_count);
      $display("Compared %0d pooled results against the prediction.", rsp_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/mp2a_pkg.sv
src/mp2a_if.sv
src/mp2a_ram.sv
src/max_pool_2d_argmax.sv
tb/pool_checker.sv
tb/tb_top.sv
